// ----- rtl/fsba_pkg.sv -----
// ----------------------------------------------------------------------------
// fsba_pkg
// shared constants, codes and control types of the block allocator
// ----------------------------------------------------------------------------
package fsba_pkg;

  localparam int MAX_BLOCKS_DEF = 32;
  localparam int ADDR_BITS_DEF  = 16;
  localparam int CNT_W_DEF      = 6;
  localparam int STRAT_W        = 3;
  localparam int POOL_W         = 17;
  localparam int CFG_DW         = 17;
  localparam int CFG_IW         = 1;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;

  localparam logic [STRAT_W-1:0] STRAT_FIRST = 3'd1;
  localparam logic [STRAT_W-1:0] STRAT_BEST  = 3'd2;
  localparam logic [STRAT_W-1:0] STRAT_WORST = 3'd3;
  localparam logic [STRAT_W-1:0] STRAT_NEXT  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_STRATEGY = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_POOL     = 1'b1;

  localparam logic [POOL_W-1:0] POOL_RESET = 17'h10000;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_EV, S_DECIDE, S_WR_EXACT,
    S_UP_RD, S_UP_WR, S_SPLIT_HI, S_SPLIT_LO, S_MERGE, S_DN_RD, S_DN_WR,
    S_SHRINK, S_STAT_CLR, S_STAT_RD, S_STAT_EV, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_INIT, OP_LATCH, OP_CLR, OP_RD, OP_RD_UP, OP_RD_DN, OP_SCAN_EV,
    OP_FAIL1, OP_FAIL2, OP_PICK, OP_WR_EXACT, OP_SPLIT_HI, OP_SPLIT_LO,
    OP_MERGE, OP_WR_SHIFT, OP_SHRINK, OP_STAT_CLR, OP_STAT_EV, OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic       is_alloc;
    logic       is_free;
    logic       size_zero;
    logic       strat_bad;
    logic       sel_ok;
    logic       need_split;
    logic       full;
    logic       free_ok;
    logic       out_free;
    logic [1:0] k;
  } sts_t;

endpackage

// ----- rtl/fsba_if.sv -----
// ----------------------------------------------------------------------------
// fsba_if
// request and result channels of the block allocator
// ----------------------------------------------------------------------------
interface fsba_req_if #(
  parameter int ADDR_BITS = fsba_pkg::ADDR_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [ADDR_BITS:0]   request_size;
  logic [ADDR_BITS-1:0] block_address;

  modport source (output valid, req_type, request_size, block_address, input ready);
  modport sink (input valid, req_type, request_size, block_address, output ready);
endinterface

interface fsba_rsp_if #(
  parameter int ADDR_BITS = fsba_pkg::ADDR_BITS_DEF,
  parameter int CNT_W     = fsba_pkg::CNT_W_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] granted_address;
  logic [CNT_W-1:0]     hole_count;
  logic [ADDR_BITS:0]   allocated_bytes;
  logic [ADDR_BITS:0]   free_bytes;
  logic [ADDR_BITS:0]   largest_free;
  logic [CNT_W-1:0]     small_hole_count;
  logic                 address_in_use;

  modport source (output valid, status, granted_address, hole_count, allocated_bytes,
                  free_bytes, largest_free, small_hole_count, address_in_use,
                  input ready);
  modport sink (input valid, status, granted_address, hole_count, allocated_bytes,
                free_bytes, largest_free, small_hole_count, address_in_use,
                output ready);
endinterface

// ----- rtl/fsba_ram.sv -----
// ----------------------------------------------------------------------------
// fsba_ram
// generic single write, single registered read memory
// ----------------------------------------------------------------------------
module fsba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/fsba_ctrl.sv -----
// ----------------------------------------------------------------------------
// fsba_ctrl
// sequencer: table scans, entry shifts, statistics pass, result hand-off
// ----------------------------------------------------------------------------
module fsba_ctrl #(
  parameter int MAX_BLOCKS = fsba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fsba_pkg::sts_t                sts,
  input  logic [$clog2(MAX_BLOCKS+1)-1:0] count,
  input  logic [$clog2(MAX_BLOCKS)-1:0]   idx,
  input  logic [$clog2(MAX_BLOCKS+1)-1:0] dn_start,
  output fsba_pkg::cmd_t                cmd,
  output logic [$clog2(MAX_BLOCKS+1)-1:0] i_out
);
  import fsba_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS + 1);

  state_t        state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW:0]   i_ext, cnt_ext;

  assign i_ext   = (IW+1)'(i_r);
  assign cnt_ext = (IW+1)'(count);
  assign i_out   = i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    cmd.op    = OP_NOP;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        i_nxt = '0;
        if (sts.is_alloc && (sts.size_zero || sts.strat_bad)) begin
          cmd.op    = OP_FAIL1;
          state_nxt = S_STAT_CLR;
        end else if (sts.is_alloc || sts.is_free) begin
          cmd.op    = OP_CLR;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_STAT_CLR;
        end
      end
      S_SCAN_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.op = OP_SCAN_EV;
        if (i_ext + 1'b1 < cnt_ext) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_alloc) begin
          if (!sts.sel_ok) begin
            cmd.op    = OP_FAIL1;
            state_nxt = S_STAT_CLR;
          end else if (sts.need_split && sts.full) begin
            cmd.op    = OP_FAIL2;
            state_nxt = S_STAT_CLR;
          end else begin
            cmd.op    = OP_PICK;
            i_nxt     = count;
            state_nxt = sts.need_split ? S_UP_RD : S_WR_EXACT;
          end
        end else if (!sts.free_ok) begin
          cmd.op    = OP_FAIL1;
          state_nxt = S_STAT_CLR;
        end else begin
          state_nxt = S_MERGE;
        end
      end
      S_WR_EXACT: begin
        cmd.op    = OP_WR_EXACT;
        state_nxt = S_STAT_CLR;
      end
      S_UP_RD: begin
        if (i_ext > (IW+1)'(idx) + 1'b1) begin
          cmd.op    = OP_RD_UP;
          state_nxt = S_UP_WR;
        end else begin
          state_nxt = S_SPLIT_HI;
        end
      end
      S_UP_WR: begin
        cmd.op    = OP_WR_SHIFT;
        i_nxt     = i_r - 1'b1;
        state_nxt = S_UP_RD;
      end
      S_SPLIT_HI: begin
        cmd.op    = OP_SPLIT_HI;
        state_nxt = S_SPLIT_LO;
      end
      S_SPLIT_LO: begin
        cmd.op    = OP_SPLIT_LO;
        state_nxt = S_STAT_CLR;
      end
      S_MERGE: begin
        cmd.op    = OP_MERGE;
        i_nxt     = dn_start;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (i_ext + (IW+1)'(sts.k) < cnt_ext) begin
          cmd.op    = OP_RD_DN;
          state_nxt = S_DN_WR;
        end else begin
          state_nxt = S_SHRINK;
        end
      end
      S_DN_WR: begin
        cmd.op    = OP_WR_SHIFT;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_DN_RD;
      end
      S_SHRINK: begin
        cmd.op    = OP_SHRINK;
        state_nxt = S_STAT_CLR;
      end
      S_STAT_CLR: begin
        cmd.op    = OP_STAT_CLR;
        i_nxt     = '0;
        state_nxt = S_STAT_RD;
      end
      S_STAT_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_STAT_EV;
      end
      S_STAT_EV: begin
        cmd.op = OP_STAT_EV;
        if (i_ext + 1'b1 < cnt_ext) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_STAT_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
    if (cfg_we) begin
      state_nxt = S_INIT;
    end
  end
endmodule

// ----- rtl/fsba_dp.sv -----
// ----------------------------------------------------------------------------
// fsba_dp
// block table, fit selection, merge arithmetic, statistics and result register
// ----------------------------------------------------------------------------
module fsba_dp #(
  parameter int MAX_BLOCKS = fsba_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = fsba_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fsba_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [fsba_pkg::CFG_DW-1:0]       cfg_wdata,
  input  fsba_pkg::cmd_t                    cmd,
  input  logic [$clog2(MAX_BLOCKS+1)-1:0]   i_in,
  input  logic [1:0]                        req_type,
  input  logic [ADDR_BITS:0]                request_size,
  input  logic [ADDR_BITS-1:0]              block_address,
  output fsba_pkg::sts_t                    sts,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]   count,
  output logic [$clog2(MAX_BLOCKS)-1:0]     idx,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]   dn_start,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [ADDR_BITS-1:0]              out_granted,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]   out_holes,
  output logic [ADDR_BITS:0]                out_alloc_b,
  output logic [ADDR_BITS:0]                out_free_b,
  output logic [ADDR_BITS:0]                out_largest,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]   out_small,
  output logic                              out_in_use
);
  import fsba_pkg::*;

  localparam int AB = ADDR_BITS;
  localparam int LW = ADDR_BITS + 1;
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int IW = $clog2(MAX_BLOCKS + 1);
  localparam int W  = AB + LW + 1;
  localparam int EW = (LW > POOL_W) ? LW : POOL_W;

  // configuration and table state
  logic [STRAT_W-1:0] strat_r;
  logic [POOL_W-1:0]  pool_r;
  logic [IW-1:0]      count_r;
  logic [AB-1:0]      rover_r;
  // latched request
  logic [1:0]         req_r;
  logic [LW-1:0]      size_r;
  logic [AB-1:0]      addr_r;
  // fit candidates
  logic               f0_ok_r, f1_ok_r, bw_ok_r, start_r;
  logic [AW-1:0]      f0_idx_r, f1_idx_r, bw_idx_r;
  logic [AB-1:0]      f0_base_r, f1_base_r, bw_base_r;
  logic [LW-1:0]      f0_len_r, f1_len_r, bw_len_r;
  // picked or matched entry and neighbors
  logic [AW-1:0]      idx_r;
  logic [AB-1:0]      pk_base_r, pbase_r, prev_base_r;
  logic [LW-1:0]      pk_len_r, plen_r, nlen_r, prev_len_r;
  logic               found_r, cur_used_r, pfree_r, nfree_r, prev_used_r;
  // statistics
  logic [1:0]         status_r;
  logic [AB-1:0]      granted_r;
  logic [IW-1:0]      holes_r, small_r;
  logic [LW-1:0]      alloc_b_r, free_b_r, largest_r;
  logic               in_use_r;
  // result register
  logic               o_valid_r, o_in_use_r;
  logic [1:0]         o_status_r;
  logic [AB-1:0]      o_granted_r;
  logic [IW-1:0]      o_holes_r, o_small_r;
  logic [LW-1:0]      o_alloc_r, o_free_r, o_largest_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr, i_addr;
  logic [W-1:0]       ram_wdata, rdata;
  logic [AB-1:0]      e_base;
  logic [LW-1:0]      e_len;
  logic               e_used, e_fit, e_hit, e_start;
  logic [EW-1:0]      pool_ext, pool_lim;
  logic [LW-1:0]      init_len;
  logic               sel_ok;
  logic [AW-1:0]      sel_idx;
  logic [AB-1:0]      sel_base;
  logic [LW-1:0]      sel_len;
  logic [LW-1:0]      merge_len;
  logic [1:0]         k;

  fsba_ram #(.WIDTH(W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign e_base = rdata[AB-1:0];
  assign e_len  = rdata[AB+LW-1:AB];
  assign e_used = rdata[W-1];
  assign i_addr = i_in[AW-1:0];

  assign e_fit   = !e_used && (e_len >= size_r);
  assign e_hit   = (rover_r >= e_base) && ((LW'(rover_r) - LW'(e_base)) < e_len);
  assign e_start = start_r || e_hit;

  // zero pool means one byte, oversize saturates at the address space
  assign pool_ext = EW'(pool_r);
  assign pool_lim = EW'(1) << AB;
  always_comb begin
    if (pool_ext == '0) begin
      init_len = LW'(1);
    end else if (pool_ext > pool_lim) begin
      init_len = LW'(pool_lim);
    end else begin
      init_len = LW'(pool_ext);
    end
  end

  always_comb begin
    sel_ok   = 1'b0;
    sel_idx  = f0_idx_r;
    sel_base = f0_base_r;
    sel_len  = f0_len_r;
    case (strat_r)
      STRAT_FIRST: sel_ok = f0_ok_r;
      STRAT_NEXT: begin
        if (f1_ok_r) begin
          sel_ok   = 1'b1;
          sel_idx  = f1_idx_r;
          sel_base = f1_base_r;
          sel_len  = f1_len_r;
        end else begin
          sel_ok = f0_ok_r;
        end
      end
      STRAT_BEST, STRAT_WORST: begin
        sel_ok   = bw_ok_r;
        sel_idx  = bw_idx_r;
        sel_base = bw_base_r;
        sel_len  = bw_len_r;
      end
      default: sel_ok = 1'b0;
    endcase
  end

  assign k         = {1'b0, pfree_r} + {1'b0, nfree_r};
  assign merge_len = (pfree_r ? plen_r : '0) + pk_len_r + (nfree_r ? nlen_r : '0);
  assign dn_start  = IW'(idx_r) + IW'(!pfree_r);

  assign sts.is_alloc   = (req_r == REQ_ALLOC);
  assign sts.is_free    = (req_r == REQ_FREE);
  assign sts.size_zero  = (size_r == '0);
  assign sts.strat_bad  = !(strat_r inside {[STRAT_FIRST:STRAT_NEXT]});
  assign sts.sel_ok     = sel_ok;
  assign sts.need_split = (sel_len != size_r);
  assign sts.full       = (count_r >= IW'(MAX_BLOCKS));
  assign sts.free_ok    = found_r && cur_used_r;
  assign sts.out_free   = !o_valid_r || out_ready;
  assign sts.k          = k;
  assign count          = count_r;
  assign idx            = idx_r;

  // table port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = rdata;
    ram_raddr = i_addr;
    case (cmd.op)
      OP_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b0, init_len, AB'(0)};
      end
      OP_RD_UP: ram_raddr = AW'(i_in - 1'b1);
      OP_RD_DN: ram_raddr = AW'((IW+1)'(i_in) + (IW+1)'(k));
      OP_WR_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = i_addr;
      end
      OP_WR_EXACT: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, pk_len_r, pk_base_r};
      end
      OP_SPLIT_HI: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + 1'b1;
        ram_wdata = {1'b0, pk_len_r - size_r, AB'(LW'(pk_base_r) + size_r)};
      end
      OP_SPLIT_LO: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, size_r, pk_base_r};
      end
      OP_MERGE: begin
        ram_we = 1'b1;
        if (pfree_r) begin
          ram_waddr = idx_r - 1'b1;
          ram_wdata = {1'b0, merge_len, pbase_r};
        end else begin
          ram_wdata = {1'b0, merge_len, pk_base_r};
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strat_r   <= '0;
      pool_r    <= POOL_RESET;
      count_r   <= IW'(1);
      rover_r   <= '0;
      o_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STRATEGY: strat_r <= cfg_wdata[STRAT_W-1:0];
          CFG_POOL:     pool_r  <= cfg_wdata[POOL_W-1:0];
          default:      strat_r <= strat_r;
        endcase
      end
      // a load may coincide with the previous result leaving
      if (cmd.op == OP_OUT_LOAD) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_INIT: begin
          count_r <= IW'(1);
          rover_r <= '0;
        end
        OP_LATCH: begin
          req_r     <= req_type;
          size_r    <= request_size;
          addr_r    <= block_address;
          status_r  <= ST_OK;
          granted_r <= '0;
        end
        OP_CLR: begin
          f0_ok_r     <= 1'b0;
          f1_ok_r     <= 1'b0;
          bw_ok_r     <= 1'b0;
          start_r     <= 1'b0;
          found_r     <= 1'b0;
          nfree_r     <= 1'b0;
          pfree_r     <= 1'b0;
          prev_used_r <= 1'b1;
        end
        OP_SCAN_EV: begin
          if (req_r == REQ_ALLOC) begin
            if (e_fit && !f0_ok_r) begin
              f0_ok_r   <= 1'b1;
              f0_idx_r  <= i_addr;
              f0_base_r <= e_base;
              f0_len_r  <= e_len;
            end
            if (e_hit) begin
              start_r <= 1'b1;
            end
            if (e_start && e_fit && !f1_ok_r) begin
              f1_ok_r   <= 1'b1;
              f1_idx_r  <= i_addr;
              f1_base_r <= e_base;
              f1_len_r  <= e_len;
            end
            if (e_fit && (!bw_ok_r || (strat_r == STRAT_BEST && e_len < bw_len_r) ||
                          (strat_r == STRAT_WORST && e_len > bw_len_r))) begin
              bw_ok_r   <= 1'b1;
              bw_idx_r  <= i_addr;
              bw_base_r <= e_base;
              bw_len_r  <= e_len;
            end
          end else begin
            // the entry just below the match and the one just above it
            if (!found_r && e_base == addr_r) begin
              found_r    <= 1'b1;
              idx_r      <= i_addr;
              cur_used_r <= e_used;
              pk_base_r  <= e_base;
              pk_len_r   <= e_len;
              pfree_r    <= !prev_used_r;
              pbase_r    <= prev_base_r;
              plen_r     <= prev_len_r;
            end
            if (found_r && (IW+1)'(i_in) == (IW+1)'(idx_r) + 1'b1) begin
              nfree_r <= !e_used;
              nlen_r  <= e_len;
            end
            prev_used_r <= e_used;
            prev_base_r <= e_base;
            prev_len_r  <= e_len;
          end
        end
        OP_FAIL1: status_r <= ST_NOFIT;
        OP_FAIL2: status_r <= ST_FULL;
        OP_PICK: begin
          idx_r     <= sel_idx;
          pk_base_r <= sel_base;
          pk_len_r  <= sel_len;
        end
        OP_WR_EXACT, OP_SPLIT_LO: begin
          rover_r   <= pk_base_r;
          granted_r <= pk_base_r;
          if (cmd.op == OP_SPLIT_LO) begin
            count_r <= count_r + 1'b1;
          end
        end
        OP_SHRINK: count_r <= count_r - IW'(k);
        OP_STAT_CLR: begin
          holes_r   <= '0;
          small_r   <= '0;
          alloc_b_r <= '0;
          free_b_r  <= '0;
          largest_r <= '0;
          in_use_r  <= 1'b0;
        end
        OP_STAT_EV: begin
          if (e_used) begin
            alloc_b_r <= alloc_b_r + e_len;
            if (e_base == addr_r) begin
              in_use_r <= 1'b1;
            end
          end else begin
            holes_r  <= holes_r + 1'b1;
            free_b_r <= free_b_r + e_len;
            if (e_len > largest_r) begin
              largest_r <= e_len;
            end
            if (e_len <= size_r) begin
              small_r <= small_r + 1'b1;
            end
          end
        end
        OP_OUT_LOAD: begin
          o_status_r  <= status_r;
          o_granted_r <= granted_r;
          o_holes_r   <= holes_r;
          o_small_r   <= small_r;
          o_alloc_r   <= alloc_b_r;
          o_free_r    <= free_b_r;
          o_largest_r <= largest_r;
          o_in_use_r  <= in_use_r;
        end
        default: count_r <= count_r;
      endcase
    end
  end

  assign out_valid   = o_valid_r;
  assign out_status  = o_status_r;
  assign out_granted = o_granted_r;
  assign out_holes   = o_holes_r;
  assign out_alloc_b = o_alloc_r;
  assign out_free_b  = o_free_r;
  assign out_largest = o_largest_r;
  assign out_small   = o_small_r;
  assign out_in_use  = o_in_use_r;
endmodule

// ----- rtl/fit_strategy_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// fit_strategy_block_allocator_top
// address-ordered block table allocator with first, best, worst and next fit
// ----------------------------------------------------------------------------
// alloc or free: table scan, entry shifts and split or merge writes, then a
//   statistics pass; query: statistics pass only; one entry read at a time
// one request at a time; a new request is taken once the result is parked in
//   the output register
// reset and any register write: table becomes one free block of pool_size at
//   base 0, rover back to 0
module fit_strategy_block_allocator_top #(
  parameter int MAX_BLOCKS = fsba_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = fsba_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  fsba_req_if.sink                    in_req,
  fsba_rsp_if.source                  out_rsp,
  input  logic                        cfg_we,
  input  logic [fsba_pkg::CFG_IW-1:0] cfg_index,
  input  logic [fsba_pkg::CFG_DW-1:0] cfg_wdata
);
  import fsba_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(MAX_BLOCKS);

  // command and status between sequencer and datapath
  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] count;
  logic [IW-1:0] i_cur;
  logic [IW-1:0] dn_start;
  logic [AW-1:0] idx;
  logic          in_ready;

  assign in_req.ready = in_ready;

  // sequencer holds the walk state; the datapath owns every other stored value
  fsba_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .count    (count),
    .idx      (idx),
    .dn_start (dn_start),
    .cmd      (cmd),
    .i_out    (i_cur)
  );

  // table memory, fit candidates, merge math, statistics, result register
  fsba_dp #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .i_in          (i_cur),
    .req_type      (in_req.req_type),
    .request_size  (in_req.request_size),
    .block_address (in_req.block_address),
    .sts           (sts),
    .count         (count),
    .idx           (idx),
    .dn_start      (dn_start),
    .out_ready     (out_rsp.ready),
    .out_valid     (out_rsp.valid),
    .out_status    (out_rsp.status),
    .out_granted   (out_rsp.granted_address),
    .out_holes     (out_rsp.hole_count),
    .out_alloc_b   (out_rsp.allocated_bytes),
    .out_free_b    (out_rsp.free_bytes),
    .out_largest   (out_rsp.largest_free),
    .out_small     (out_rsp.small_hole_count),
    .out_in_use    (out_rsp.address_in_use)
  );
endmodule

// ----- rtl/fsba_checker.sv -----
// ----------------------------------------------------------------------------
// fsba_checker
// port-level checks on the allocator result stream
// ----------------------------------------------------------------------------
module fsba_checker #(
  parameter int LW = fsba_pkg::ADDR_BITS_DEF + 1,
  parameter int AB = fsba_pkg::ADDR_BITS_DEF,
  parameter int CW = fsba_pkg::CNT_W_DEF
) (
  input logic          clk,
  input logic          rst_n,
  input logic          o_valid,
  input logic          o_ready,
  input logic [1:0]    status,
  input logic [AB-1:0] granted,
  input logic [CW-1:0] holes,
  input logic [LW-1:0] free_b,
  input logic [LW-1:0] largest,
  input logic [CW-1:0] small_cnt
);
  import fsba_pkg::*;

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && status != ST_OK |-> granted == '0)
    else $error("failed request reports a granted address");

  a_holes_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> (holes == '0) == (free_b == '0))
    else $error("hole count and free bytes disagree");

  a_largest: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> largest <= free_b && small_cnt <= holes)
    else $error("largest hole or small hole count out of bounds");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> o_valid && $stable(status) && $stable(free_b))
    else $error("stalled result changed");
endmodule

bind fit_strategy_block_allocator_top fsba_checker #(
  .LW(ADDR_BITS + 1), .AB(ADDR_BITS), .CW($clog2(MAX_BLOCKS + 1))
) u_fsba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .o_valid   (out_rsp.valid),
  .o_ready   (out_rsp.ready),
  .status    (out_rsp.status),
  .granted   (out_rsp.granted_address),
  .holes     (out_rsp.hole_count),
  .free_b    (out_rsp.free_bytes),
  .largest   (out_rsp.largest_free),
  .small_cnt (out_rsp.small_hole_count)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// random and directed requests against the block allocator, with every result
// checked against a behavioral model of the block table kept in the scoreboard
// ----------------------------------------------------------------------------
module tb_top;
  import fsba_pkg::*;

  localparam int NBLK = MAX_BLOCKS_DEF;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_ODD   = 2'd3;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted;
    logic [5:0]  holes;
    logic [16:0] alloc_b;
    logic [16:0] free_b;
    logic [16:0] largest;
    logic [5:0]  small_cnt;
    logic        in_use;
  } rsp_t;

  // model of the block table plus the queue of predicted results
  class alloc_scoreboard;
    int unsigned base_q[NBLK];
    int unsigned len_q[NBLK];
    bit          used_q[NBLK];
    int          count;
    int unsigned rover;
    int unsigned strategy;
    int unsigned pool;
    rsp_t        pending[$];
    int          errors;

    function void table_init();
      int unsigned sz;
      sz = pool;
      if (sz == 0) sz = 1;
      if (sz > 65536) sz = 65536;
      for (int i = 0; i < NBLK; i++) begin
        base_q[i] = 0; len_q[i] = 0; used_q[i] = 0;
      end
      len_q[0] = sz;
      count = 1;
      rover = 0;
    endfunction

    function void reset_state();
      strategy = 0;
      pool = 65536;
      errors = 0;
      table_init();
    endfunction

    function void write_reg(int idx, int unsigned val);
      if (idx == CFG_STRATEGY) strategy = val & 7;
      else pool = val & 17'h1ffff;
      table_init();
    endfunction

    function void drop_entry(int idx);
      for (int i = idx; i + 1 < count; i++) begin
        base_q[i] = base_q[i+1]; len_q[i] = len_q[i+1]; used_q[i] = used_q[i+1];
      end
      count--;
      base_q[count] = 0; len_q[count] = 0; used_q[count] = 0;
    endfunction

    function int pick_block(int unsigned sz);
      int pk, st, j;
      pk = count;
      st = 0;
      case (strategy)
        STRAT_FIRST: begin
          for (int i = 0; i < count; i++)
            if (!used_q[i] && len_q[i] >= sz) return i;
        end
        STRAT_BEST, STRAT_WORST: begin
          for (int i = 0; i < count; i++) begin
            if (used_q[i] || len_q[i] < sz) continue;
            if (pk == count || (strategy == STRAT_BEST && len_q[i] < len_q[pk]) ||
                (strategy == STRAT_WORST && len_q[i] > len_q[pk]))
              pk = i;
          end
        end
        STRAT_NEXT: begin
          for (int i = 0; i < count; i++)
            if (rover >= base_q[i] && rover - base_q[i] < len_q[i]) begin
              st = i;
              break;
            end
          for (int i = 0; i < count; i++) begin
            j = (st + i) % count;
            if (!used_q[j] && len_q[j] >= sz) return j;
          end
        end
        default: ;
      endcase
      return pk;
    endfunction

    // notes an accepted request and predicts its result
    function void note_request(logic [1:0] rt, logic [16:0] sz, logic [15:0] addr);
      rsp_t r;
      int idx;
      r = '0;
      if (rt == REQ_ALLOC) begin
        if (sz == 0) r.status = ST_NOFIT;
        else begin
          idx = pick_block(sz);
          if (idx >= count) r.status = ST_NOFIT;
          else if (len_q[idx] != sz && count >= NBLK) r.status = ST_FULL;
          else begin
            if (len_q[idx] != sz) begin
              for (int i = count; i > idx + 1; i--) begin
                base_q[i] = base_q[i-1]; len_q[i] = len_q[i-1]; used_q[i] = used_q[i-1];
              end
              base_q[idx+1] = base_q[idx] + sz;
              len_q[idx+1] = len_q[idx] - sz;
              used_q[idx+1] = 0;
              len_q[idx] = sz;
              count++;
            end
            used_q[idx] = 1;
            rover = base_q[idx];
            r.granted = 16'(base_q[idx]);
          end
        end
      end else if (rt == REQ_FREE) begin
        idx = count;
        for (int i = 0; i < count; i++)
          if (base_q[i] == addr) begin
            idx = i;
            break;
          end
        if (idx >= count || !used_q[idx]) r.status = ST_NOFIT;
        else begin
          used_q[idx] = 0;
          if (idx > 0 && !used_q[idx-1]) begin
            len_q[idx-1] += len_q[idx];
            drop_entry(idx);
            idx--;
          end
          if (idx + 1 < count && !used_q[idx+1]) begin
            len_q[idx] += len_q[idx+1];
            drop_entry(idx + 1);
          end
        end
      end
      for (int i = 0; i < count; i++) begin
        if (used_q[i]) begin
          r.alloc_b = 17'(r.alloc_b + len_q[i]);
          if (base_q[i] == addr) r.in_use = 1;
        end else begin
          r.holes++;
          r.free_b = 17'(r.free_b + len_q[i]);
          if (len_q[i] > r.largest) r.largest = 17'(len_q[i]);
          if (len_q[i] <= sz) r.small_cnt++;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        $display("%0t: mismatch expected %p actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  fsba_req_if in_req ();
  fsba_rsp_if out_rsp ();

  fit_strategy_block_allocator_top dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  alloc_scoreboard sb = new();
  bit idle_on = 1'b1;
  int cycles = 0;
  // addresses handed out and not yet freed, for well-formed free requests
  logic [15:0] live[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random back-pressure bursts, compare at the rising edge
  initial begin
    int stall;
    out_rsp.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_rsp.ready <= 1'b0;
        stall = $urandom_range(1, 5);
        repeat (stall) @(negedge clk);
      end
      out_rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_t got;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got = {out_rsp.status, out_rsp.granted_address, out_rsp.hole_count,
             out_rsp.allocated_bytes, out_rsp.free_bytes, out_rsp.largest_free,
             out_rsp.small_hole_count, out_rsp.address_in_use};
      sb.check_result(got);
    end
  end

  // one request; prediction is made at the accepting edge
  task automatic send_req(logic [1:0] rt, logic [16:0] sz, logic [15:0] addr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.req_type <= rt;
    in_req.request_size <= sz;
    in_req.block_address <= addr;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(rt, sz, addr);
    if (rt == REQ_ALLOC && sb.pending[$].status == ST_OK)
      live.push_back(sb.pending[$].granted);
    @(negedge clk);
  endtask

  // registers only change with the block idle and all results back
  task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    in_req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    live.delete();
    repeat (4) @(negedge clk);
  endtask

  task automatic free_random_live();
    int k;
    logic [15:0] a;
    k = $urandom_range(0, live.size() - 1);
    a = live[k];
    live.delete(k);
    send_req(REQ_FREE, 17'($urandom_range(0, 17'h1ffff)), a);
  endtask

  // mostly allocs and frees of live blocks, some queries and junk
  task automatic random_phase(int n, int unsigned maxsz);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send_req(REQ_ALLOC, 17'($urandom_range(1, maxsz)), 16'($urandom));
      else if (r < 80 && live.size() > 0)
        free_random_live();
      else if (r < 88)
        send_req(REQ_FREE, 17'($urandom_range(0, 17'h1ffff)), 16'($urandom));
      else if (r < 94)
        send_req(($urandom_range(0, 1) ? REQ_QUERY : REQ_ODD),
                 17'($urandom_range(0, 17'h1ffff)),
                 live.size() > 0 ? live[0] : 16'($urandom));
      else
        send_req(REQ_ALLOC, 17'($urandom_range(0, 17'h1ffff)), 16'($urandom));
    end
  endtask

  initial begin
    in_req.valid = 1'b0;
    in_req.req_type = REQ_ALLOC;
    in_req.request_size = '0;
    in_req.block_address = '0;
    sb.reset_state();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(negedge clk);

    // directed: reset strategy none, then extremes and special cases
    send_req(REQ_ALLOC, 17'd16, 16'd0);
    send_req(REQ_QUERY, 17'h1ffff, 16'hffff);
    write_cfg(CFG_STRATEGY, CFG_DW'(STRAT_FIRST));
    send_req(REQ_ALLOC, 17'd0, 16'd0);
    send_req(REQ_ALLOC, 17'd100, 16'd0);
    send_req(REQ_ALLOC, 17'd200, 16'd100);
    send_req(REQ_FREE, 17'd0, 16'd0);
    send_req(REQ_FREE, 17'd0, 16'd0);
    send_req(REQ_FREE, 17'd0, 16'd7);
    send_req(REQ_FREE, 17'd300, 16'd100);
    send_req(REQ_ALLOC, 17'h10000, 16'hffff);
    send_req(REQ_ALLOC, 17'h10001, 16'd0);
    send_req(REQ_ODD, 17'h10000, 16'd0);
    send_req(REQ_FREE, 17'h1ffff, 16'd0);
    // fill the table with one-byte splits until it reports full
    write_cfg(CFG_POOL, 17'd64);
    for (int i = 0; i < 33; i++) send_req(REQ_ALLOC, 17'd1, 16'($urandom));
    send_req(REQ_ALLOC, 17'd32, 16'd31);
    write_cfg(CFG_POOL, 17'd0);
    send_req(REQ_ALLOC, 17'd1, 16'd0);
    write_cfg(CFG_POOL, 17'h1ffff);
    send_req(REQ_QUERY, 17'h10000, 16'd0);

    // random phases over all strategies and pool sizes
    for (int ph = 0; ph < 12; ph++) begin
      write_cfg(CFG_STRATEGY, CFG_DW'(ph < 10 ? (ph % 4) + 1 : (ph == 10 ? 5 : 7)));
      case (ph % 4)
        0: write_cfg(CFG_POOL, 17'h10000);
        1: write_cfg(CFG_POOL, 17'd1);
        2: write_cfg(CFG_POOL, CFG_DW'($urandom_range(2, 4096)));
        default: write_cfg(CFG_POOL, CFG_DW'($urandom_range(256, 17'h1ffff)));
      endcase
      if (ph == 11) idle_on = 1'b1;
      random_phase(ph % 4 == 1 ? 30 : 150, ph % 4 == 0 ? 4096 : 600);
    end
    write_cfg(CFG_STRATEGY, CFG_DW'(STRAT_NEXT));
    random_phase(50, 2000);
    // closing stretch runs without idle cycles on either side
    idle_on = 1'b0;
    random_phase(100, 2000);

    in_req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/fsba_pkg.sv
rtl/fsba_if.sv
rtl/fsba_ram.sv
rtl/fsba_ctrl.sv
rtl/fsba_dp.sv
rtl/fit_strategy_block_allocator_top.sv
rtl/fsba_checker.sv
sim/tb_top.sv
